/* rtl/core/gf2_poly_binary_gcd_core_macros.svh */
// ----------------------------------------------------------------------------
// GF(2) polynomial gcd core: assertion macros
// Short forms for the concurrent checks used inside the core.
// ----------------------------------------------------------------------------
`ifndef GF2_POLY_BINARY_GCD_CORE_MACROS_SVH
`define GF2_POLY_BINARY_GCD_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define GF2G_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define GF2G_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/gf2g_pkg.sv */
// ----------------------------------------------------------------------------
// GF(2) polynomial gcd core: package
// Field widths shared by the channel interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package gf2g_pkg;

   // width of a polynomial on the channels (bit i = coefficient of x^i)
   localparam int PORT_W = 32;
   // width of the reported gcd degree
   localparam int DEG_W  = 5;

endpackage

`default_nettype wire

/* rtl/core/gf2g_req_if.sv */
// ----------------------------------------------------------------------------
// GF(2) polynomial gcd core: request channel
// Valid/ready channel carrying the two operand polynomials.
// ----------------------------------------------------------------------------
`default_nettype none

interface gf2g_req_if;

   logic                          valid;
   logic                          ready;
   logic [gf2g_pkg::PORT_W-1:0]   poly_a;
   logic [gf2g_pkg::PORT_W-1:0]   poly_b;

   modport source (output valid, output poly_a, output poly_b, input ready);
   modport sink   (input valid, input poly_a, input poly_b, output ready);

endinterface

`default_nettype wire

/* rtl/core/gf2g_rsp_if.sv */
// ----------------------------------------------------------------------------
// GF(2) polynomial gcd core: response channel
// Valid/ready channel carrying the gcd polynomial and its degree.
// ----------------------------------------------------------------------------
`default_nettype none

interface gf2g_rsp_if;

   logic                          valid;
   logic                          ready;
   logic [gf2g_pkg::PORT_W-1:0]   gcd_poly;
   logic [gf2g_pkg::DEG_W-1:0]    gcd_degree;

   modport source (output valid, output gcd_poly, output gcd_degree, input ready);
   modport sink   (input valid, input gcd_poly, input gcd_degree, output ready);

endinterface

`default_nettype wire

/* rtl/core/gf2_poly_binary_gcd_core.sv */
// ----------------------------------------------------------------------------
// GF(2) polynomial gcd core
// Binary (Stein) gcd of two GF(2) polynomials, one reduction step per stage.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch (sink) takes poly_a / poly_b; a transfer happens at a rising edge
//   with valid and ready both high. Coefficients above x^MAX_DEGREE are dropped.
//   rsp_ch (source) returns gcd_poly and gcd_degree, one transfer per request,
//   in request order. A zero operand yields the other operand; zero and zero
//   yields zero with degree zero.
//   A request passes through stage 0, the step stages, the finishing stage and
//   the output register to rsp_ch. W = min(MAX_DEGREE+1, 32); the reduction
//   runs through 2*W-1 step stages, each doing one shift or one XOR-and-shift,
//   so the length is set by the worst-case count of steps (one degree per step).
//   Throughput: one transfer per cycle on both channels when not stalled.
//   Stall: the whole pipeline holds while the output register is full and not
//   taken, unless the finishing stage is empty; in that case the pipeline keeps
//   advancing and a new request is still taken while the result waits.
//   Reset (synchronous, active high) drops every item in flight; payload
//   registers keep their contents but are marked empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gf2_poly_binary_gcd_core_macros.svh"

module gf2_poly_binary_gcd_core #(
   parameter int MAX_DEGREE = 31
) (
   input  wire       clock,
   input  wire       reset,
   gf2g_req_if.sink   req_ch,
   gf2g_rsp_if.source rsp_ch
);

   localparam int PW     = gf2g_pkg::PORT_W;
   localparam int DW     = gf2g_pkg::DEG_W;
   // working polynomial width: coefficients x^0 .. x^MAX_DEGREE, capped at the port
   localparam int W      = (MAX_DEGREE + 1 < PW) ? MAX_DEGREE + 1 : PW;
   localparam int SH_W   = $clog2(W);
   // each step lowers deg(a)+deg(b) by at least one, or finishes
   localparam int NSTAGE = 2 * W - 1;

   // step pipeline: stage 0 holds the masked operands
   logic [W-1:0]    a_ff   [0:NSTAGE];
   logic [W-1:0]    a_in   [0:NSTAGE];
   logic [W-1:0]    b_ff   [0:NSTAGE];
   logic [W-1:0]    b_in   [0:NSTAGE];
   logic [SH_W-1:0] cnt_ff [0:NSTAGE];
   logic [SH_W-1:0] cnt_in [0:NSTAGE];
   logic [NSTAGE:0] vld_ff;
   logic [NSTAGE:0] vld_in;

   // finishing stage: odd part, its degree and the common x count
   logic            fin_vld_ff;
   logic [W-1:0]    fin_poly_ff;
   logic [W-1:0]    fin_poly_in;
   logic [SH_W-1:0] fin_pdeg_ff;
   logic [SH_W-1:0] fin_pdeg_in;
   logic [SH_W-1:0] fin_cnt_ff;

   // output register
   logic            rsp_vld_ff;
   logic [PW-1:0]   gcd_poly_ff;
   logic [PW-1:0]   gcd_poly_in;
   logic [DW-1:0]   gcd_degree_ff;
   logic [DW-1:0]   gcd_degree_in;
   logic [W-1:0]    fin_shift;

   logic            advance;
   logic            rsp_load;

   // output register refills when empty or being taken
   assign rsp_load = !rsp_vld_ff || rsp_ch.ready;
   // pipeline moves unless a finished item is stuck behind a stalled output
   assign advance  = rsp_load || !fin_vld_ff;

   assign req_ch.ready = advance;

   // stage 0: mask off coefficients above x^MAX_DEGREE
   always_comb begin
      a_in[0]   = req_ch.poly_a[W-1:0];
      b_in[0]   = req_ch.poly_b[W-1:0];
      cnt_in[0] = '0;
      vld_in[0] = req_ch.valid;
   end

   // one reduction step per stage
   for (genvar k = 1; k <= NSTAGE; k++) begin : g_step
      logic [W-1:0] mix;
      logic         b_higher;

      always_comb begin
         mix      = (a_ff[k-1] ^ b_ff[k-1]) >> 1;
         // deg(b) > deg(a) without a priority encoder
         b_higher = (a_ff[k-1] < b_ff[k-1]) && (a_ff[k-1] < (a_ff[k-1] ^ b_ff[k-1]));
         a_in[k]   = a_ff[k-1];
         b_in[k]   = b_ff[k-1];
         cnt_in[k] = cnt_ff[k-1];
         vld_in[k] = vld_ff[k-1];
         // hold once either operand is zero
         if ((a_ff[k-1] != '0) && (b_ff[k-1] != '0)) begin
            if (!a_ff[k-1][0] && !b_ff[k-1][0]) begin
               // common factor of x: strip from both and count it
               a_in[k]   = a_ff[k-1] >> 1;
               b_in[k]   = b_ff[k-1] >> 1;
               cnt_in[k] = cnt_ff[k-1] + SH_W'(1);
            end else if (!a_ff[k-1][0]) begin
               a_in[k] = a_ff[k-1] >> 1;
            end else if (!b_ff[k-1][0]) begin
               b_in[k] = b_ff[k-1] >> 1;
            end else if (b_higher) begin
               // both odd: the sum is even, drop its x at once
               b_in[k] = mix;
            end else begin
               a_in[k] = mix;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= NSTAGE; k++) begin
            a_ff[k]   <= a_in[k];
            b_ff[k]   <= b_in[k];
            cnt_ff[k] <= cnt_in[k];
         end
      end
   end

   // finishing stage: the nonzero operand is the odd part of the gcd, or the whole gcd when an operand was zero
   always_comb begin
      fin_poly_in = a_ff[NSTAGE] | b_ff[NSTAGE];
      fin_pdeg_in = '0;
      for (int i = 0; i < W; i++) begin
         if (fin_poly_in[i]) begin
            fin_pdeg_in = SH_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (advance) begin
         fin_vld_ff <= vld_ff[NSTAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin_poly_ff <= fin_poly_in;
         fin_pdeg_ff <= fin_pdeg_in;
         fin_cnt_ff  <= cnt_ff[NSTAGE];
      end
   end

   // restore the common x factors
   always_comb begin
      fin_shift     = fin_poly_ff << fin_cnt_ff;
      gcd_poly_in   = PW'(fin_shift);
      gcd_degree_in = DW'(SH_W'({1'b0, fin_pdeg_ff} + {1'b0, fin_cnt_ff}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_vld_ff <= fin_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         gcd_poly_ff   <= gcd_poly_in;
         gcd_degree_ff <= gcd_degree_in;
      end
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.gcd_poly   = gcd_poly_ff;
   assign rsp_ch.gcd_degree = gcd_degree_ff;

   // the step chain is long enough for the worst case
   `GF2G_ASSERT_IMP(a_steps_done, clock, reset, vld_ff[NSTAGE], (a_ff[NSTAGE] == '0) || (b_ff[NSTAGE] == '0), "gcd reduction unfinished at last step stage")

   // once common x factors were counted, the surviving operand is odd
   `GF2G_ASSERT_IMP(a_fin_odd, clock, reset, fin_vld_ff && (fin_cnt_ff != '0), fin_poly_ff[0], "odd part of gcd is even")

   // the restored gcd fits the working width
   `GF2G_ASSERT_IMP(a_fin_fits, clock, reset, fin_vld_ff, ({1'b0, fin_pdeg_ff} + {1'b0, fin_cnt_ff}) < (SH_W + 1)'(W), "gcd degree overflows working width")

   // a finished item moves into an empty output register
   `GF2G_ASSERT_NXT(a_fin_moves, clock, reset, fin_vld_ff && !rsp_vld_ff, rsp_vld_ff, "finished gcd lost before output register")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// GF(2) polynomial gcd core: testbench
// Sends operand pairs into the core over the request channel with random
// gaps and stalls the response channel at random. Every returned gcd and
// degree is checked against a local binary gcd computed in order of transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int PORT_W = gf2g_pkg::PORT_W;
   localparam int DEG_W  = gf2g_pkg::DEG_W;

   localparam int MAX_DEGREE = 31;
   // coefficients above x^MAX_DEGREE are dropped by the core
   localparam logic [PORT_W-1:0] COEF_MASK =
      (MAX_DEGREE >= PORT_W - 1) ? {PORT_W{1'b1}} :
      ((({{(PORT_W-1){1'b0}}, 1'b1}) << (MAX_DEGREE + 1)) - 1);
   // allow a margin on top of the core latency for the drain
   localparam int DRAIN_CYCLES = 2 * PORT_W + 16;
   localparam int RANDOM_PAIRS = 1850;

   typedef struct packed {
      logic [PORT_W-1:0] poly_a;
      logic [PORT_W-1:0] poly_b;
   } operand_pair_type;

   typedef struct packed {
      logic [PORT_W-1:0] gcd_poly;
      logic [DEG_W-1:0]  gcd_degree;
   } gcd_result_type;

   logic clock;
   logic reset;

   gf2g_req_if req_if ();
   gf2g_rsp_if rsp_if ();

   gf2_poly_binary_gcd_core #(
      .MAX_DEGREE (MAX_DEGREE)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // operand pairs still to be offered, and gcds still owed by the core
   operand_pair_type pending_operands [$];
   gcd_result_type   expected_gcds [$];

   int  accepted_count = 0;
   int  queued_count   = 0;
   int  fail_count     = 0;
   bit  req_taken      = 1'b0;

   int  req_gap_left   = 0;
   int  req_calm_left  = 0;
   int  rsp_hold_left  = 0;
   int  rsp_calm_left  = 0;

   // -------------------------------------------------------------------------
   // Polynomial helpers
   // -------------------------------------------------------------------------

   // index of the highest set coefficient; zero for a constant or zero
   function automatic int degree_of(logic [PORT_W-1:0] p);
      int d;
      d = 0;
      for (int i = 0; i < PORT_W; i++) begin
         if (p[i]) d = i;
      end
      return d;
   endfunction

   // binary gcd over GF(2), same step order as the core
   function automatic gcd_result_type predict_gcd(operand_pair_type pair);
      logic [PORT_W-1:0] a;
      logic [PORT_W-1:0] b;
      logic [PORT_W-1:0] g;
      int                x_count;
      gcd_result_type    res;
      a = pair.poly_a & COEF_MASK;
      b = pair.poly_b & COEF_MASK;
      x_count = 0;
      if (a == '0) begin
         g = b;
      end else if (b == '0) begin
         g = a;
      end else begin
         // strip and count the common factors of x
         while (((a | b) & 1) == 0) begin
            a = a >> 1;
            b = b >> 1;
            x_count++;
         end
         while (a != '0 && b != '0) begin
            if (!a[0]) begin
               a = a >> 1;
            end else if (!b[0]) begin
               b = b >> 1;
            end else if (degree_of(b) > degree_of(a)) begin
               b = b ^ a;
            end else begin
               // equal degree falls here: fold b into a
               a = a ^ b;
            end
         end
         g = (a | b) << x_count;
      end
      res.gcd_poly   = g;
      res.gcd_degree = DEG_W'(degree_of(g));
      return res;
   endfunction

   // carry-less product, truncated to the port width
   function automatic logic [PORT_W-1:0] clmul(logic [PORT_W-1:0] a, logic [PORT_W-1:0] b);
      logic [PORT_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < PORT_W; i++) begin
         if (b[i]) acc = acc ^ (a << i);
      end
      return acc;
   endfunction

   // random polynomial of exactly the given degree
   function automatic logic [PORT_W-1:0] rand_poly(int deg);
      logic [PORT_W-1:0] v;
      v = $urandom;
      if (deg < PORT_W - 1) v = v & ((({{(PORT_W-1){1'b0}}, 1'b1}) << (deg + 1)) - 1);
      v[deg] = 1'b1;
      return v;
   endfunction

   // gap length: mostly none or short, now and then long, with calm stretches
   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 120);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic queue_pair(logic [PORT_W-1:0] a, logic [PORT_W-1:0] b);
      operand_pair_type pair;
      pair.poly_a = a;
      pair.poly_b = b;
      pending_operands.push_back(pair);
      queued_count++;
   endtask

   // -------------------------------------------------------------------------
   // Clock
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Request driver: changes inputs on the falling edge only. A pair is held
   // until the rising edge in between has seen valid and ready together.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : drive_requests
      operand_pair_type next_pair;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap_left > 0) begin
            // idle this cycle
            req_if.valid <= 1'b0;
            req_gap_left--;
         end else if (pending_operands.size() > 0) begin
            next_pair = pending_operands.pop_front();
            req_if.poly_a <= next_pair.poly_a;
            req_if.poly_b <= next_pair.poly_b;
            req_if.valid  <= 1'b1;
            req_gap_left = pick_gap(req_calm_left);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response back-pressure: drop ready for random stretches
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_if.ready <= 1'b1;
         rsp_hold_left = pick_gap(rsp_calm_left);
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge. A request transfer
   // queues its predicted gcd; a response transfer is checked against the
   // oldest prediction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      operand_pair_type seen_pair;
      gcd_result_type   want;
      req_taken = !reset && req_if.valid && req_if.ready;
      if (req_taken) begin
         seen_pair.poly_a = req_if.poly_a;
         seen_pair.poly_b = req_if.poly_b;
         expected_gcds.push_back(predict_gcd(seen_pair));
         accepted_count++;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_gcds.size() == 0) begin
            $display("%0t: unexpected result gcd_poly=%h gcd_degree=%0d", $time,
                     rsp_if.gcd_poly, rsp_if.gcd_degree);
            fail_count++;
         end else begin
            want = expected_gcds.pop_front();
            if (rsp_if.gcd_poly !== want.gcd_poly) begin
               $display("%0t: gcd_poly mismatch, expected %h, actual %h", $time,
                        want.gcd_poly, rsp_if.gcd_poly);
               fail_count++;
            end
            if (rsp_if.gcd_degree !== want.gcd_degree) begin
               $display("%0t: gcd_degree mismatch, expected %0d, actual %0d", $time,
                        want.gcd_degree, rsp_if.gcd_degree);
               fail_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin : run_test
      logic [PORT_W-1:0] a;
      logic [PORT_W-1:0] b;
      logic [PORT_W-1:0] common;
      int                d;
      int                waited;

      // hold every input at a known value from time zero
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.poly_a = '0;
      req_if.poly_b = '0;
      rsp_if.ready  = 1'b0;

      // directed pairs: zero operands, extremes, ties and common x factors
      queue_pair('0, '0);
      queue_pair('0, 32'h0000_0001);
      queue_pair(32'h0000_0001, '0);
      queue_pair('0, 32'hFFFF_FFFF);
      queue_pair(32'hFFFF_FFFF, '0);
      queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_pair(32'h8000_0000, 32'h8000_0000);
      queue_pair(32'h8000_0000, 32'h4000_0000);
      queue_pair(32'h8000_0000, 32'h0000_0001);
      queue_pair(32'h0000_0001, 32'h0000_0001);
      queue_pair(32'h0000_0003, 32'h0000_0003);
      queue_pair(32'h0000_0006, 32'h0000_0003);
      queue_pair(32'h0000_000B, 32'h0000_000D);  // odd, equal degree
      queue_pair(32'h0000_000D, 32'h0000_000B);
      queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
      queue_pair(32'hFFFF_FFFF, 32'h8000_0001);
      queue_pair(32'h0000_0002, 32'h0000_0004);
      queue_pair(clmul(32'h0000_0007, 32'h0000_0013) << 3,
                 clmul(32'h0000_0007, 32'h0000_0019) << 5);
      queue_pair(clmul(32'h0000_8003, 32'h0000_0805), clmul(32'h0000_8003, 32'h0000_1001));
      queue_pair(32'hDEAD_BEEF, 32'hDEAD_BEEF);
      queue_pair(32'h8000_0001, 32'h0000_0003);

      // random pairs: three in ten share a factor so the reduction runs long,
      // the rest are plain or shifted noise, zeros, small and equal degrees
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               a = $urandom;
               b = $urandom;
            end
            3, 4, 5: begin
               common = rand_poly($urandom_range(0, 10));
               d = $urandom_range(0, 4);
               a = clmul(common, rand_poly($urandom_range(0, 16))) << d;
               b = clmul(common, rand_poly($urandom_range(0, 16))) << $urandom_range(0, 4);
            end
            6: begin
               a = $urandom_range(0, 1) ? $urandom : rand_poly($urandom_range(0, 31));
               b = '0;
               if ($urandom_range(0, 1)) begin
                  b = a;
                  a = '0;
               end
            end
            7: begin
               a = rand_poly($urandom_range(0, 5));
               b = rand_poly($urandom_range(0, 5));
            end
            8: begin
               d = $urandom_range(0, 31);
               a = rand_poly(d);
               b = rand_poly(d);
               a[0] = 1'b1;
               b[0] = 1'b1;
            end
            default: begin
               a = $urandom << $urandom_range(0, 31);
               b = $urandom << $urandom_range(0, 31);
            end
         endcase
         queue_pair(a, b);
      end

      // release reset on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for every pair to be taken, then for every gcd to come back
      while (accepted_count < queued_count) @(posedge clock);
      while (expected_gcds.size() > 0) @(posedge clock);
      // watch a little longer for stray results
      waited = 0;
      while (waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/gf2g_pkg.sv
rtl/core/gf2g_req_if.sv
rtl/core/gf2g_rsp_if.sv
rtl/core/gf2_poly_binary_gcd_core.sv
tb/sv/tb.sv
